// File: rtl/core/mctt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mctt_pkg: shared types for the multi-channel tick timer
// transaction structs, command codes, timer states and sequencer states
// ----------------------------------------------------------------------------
package mctt_pkg;

  localparam int unsigned IDX_W    = 4;
  localparam int unsigned RELOAD_W = 32;

  typedef enum logic [1:0] {
    FUNC_SETUP = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_TICK  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_CREATED = 2'd0,
    STATUS_STARTED = 2'd1,
    STATUS_STOPPED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CMD   = 2'd1,
    ST_TICK  = 2'd2,
    ST_FLUSH = 2'd3
  } state_e;

  typedef struct packed {
    func_e                func;
    logic [IDX_W-1:0]     timer_index;
    logic [RELOAD_W-1:0]  reload_ticks;
    logic                 periodic;
    logic                 hard_mode;
  } in_item_t;

  typedef struct packed {
    logic             is_fire;
    logic [IDX_W-1:0] fired_timer;
    status_e          timer_status;
    logic             accepted;
    logic             last;
  } out_item_t;

endpackage
`default_nettype wire

// File: rtl/core/multi_channel_tick_timer.sv
`default_nettype none
// command: acknowledgement registered when the output has room, then idle for the next accept
// tick: one timer slot per cycle through the timer table (one read, one write port) while no firing
//   waits for output room, hard pass then soft pass, then a flush of the final firing
// one transaction in flight at a time; a finished result waits in the output register
// reset: every timer stopped; table entries read as zero until first written
//   (per-entry written flags cleared by reset), no clearing pass
// ----------------------------------------------------------------------------
// multi_channel_tick_timer
// table of one-shot / periodic timers with hard and soft classes, served by a
// sequencer that walks the table through one shared decrement-and-compare unit
// ----------------------------------------------------------------------------
module multi_channel_tick_timer #(
  parameter int unsigned NUM_TIMERS  = 16,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command / tick channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mctt_pkg::in_item_t  in_data_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mctt_pkg::out_item_t out_data_o
);

  localparam int unsigned AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_TIMERS - 1);
  localparam int unsigned IW = mctt_pkg::IDX_W;

  // one table row: everything but the run state
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] reload;
    logic [COUNT_WIDTH-1:0] count;
    logic                   periodic;
    logic                   hard;
  } entry_t;

  // sequencer and command capture
  mctt_pkg::state_e    state_q, state_d;
  mctt_pkg::in_item_t  cmd_q;
  logic [AW-1:0]       ptr_q, ptr_d;      // slot under service during a tick
  logic                cls_q, cls_d;      // class being served: 1 hard, 0 soft

  // timer table (one read and one write port, registered read) with written flags
  entry_t              mem [NUM_TIMERS];
  logic                vld_q [NUM_TIMERS];
  entry_t              rd_q;
  logic                rd_vld_q;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  entry_t              wr_entry;

  // run state per timer, kept in flops so reset stops every timer at once
  mctt_pkg::status_e   run_q [NUM_TIMERS];
  logic                run_wr_en;
  mctt_pkg::status_e   run_wr_val;

  // one-deep hold of the latest firing so the final one can carry last
  logic                pend_vld_q, pend_vld_d;
  mctt_pkg::out_item_t pend_q, pend_d;

  // output register
  logic                out_vld_q;
  mctt_pkg::out_item_t out_q;
  logic                out_load;
  mctt_pkg::out_item_t out_item;
  logic                out_free;

  // shared unit inputs
  entry_t              ent;
  logic [AW-1:0]       cmd_addr;
  logic [AW-1:0]       cur_addr;
  mctt_pkg::status_e   cur_run;
  logic                idx_ok;

  // shared decrement / zero-compare unit
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic [COUNT_WIDTH-1:0] new_count;
  logic                   cnt_zero;
  logic                   part;
  logic                   fire;
  mctt_pkg::status_e      fire_status;

  assign in_stall_o  = (state_q != mctt_pkg::ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_vld_q || !out_stall_i;

  // never-written rows read as their reset value (all zero)
  assign ent      = rd_vld_q ? rd_q : '0;
  assign cmd_addr = AW'(cmd_q.timer_index);
  assign cur_addr = (state_q == mctt_pkg::ST_CMD) ? cmd_addr : ptr_q;
  assign cur_run  = run_q[cur_addr];
  assign idx_ok   = (32'(cmd_q.timer_index) < NUM_TIMERS);

  // a started timer of the class being served is decremented; it fires when
  // it was already at zero or just reached zero
  assign part        = (cur_run == mctt_pkg::STATUS_STARTED) && (ent.hard == cls_q);
  assign cnt_zero    = (ent.count == '0);
  assign cnt_dec     = ent.count - COUNT_WIDTH'(1);
  assign fire        = part && (cnt_zero || (cnt_dec == '0));
  assign new_count   = (fire && ent.periodic) ? ent.reload :
                       (cnt_zero ? '0 : cnt_dec);
  assign fire_status = ent.periodic ? mctt_pkg::STATUS_STARTED : mctt_pkg::STATUS_STOPPED;

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    cls_d      = cls_q;
    rd_en      = 1'b0;
    rd_addr    = ptr_q;
    wr_en      = 1'b0;
    wr_addr    = cur_addr;
    wr_entry   = ent;
    run_wr_en  = 1'b0;
    run_wr_val = cur_run;
    out_load   = 1'b0;
    out_item   = '0;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;

    unique case (state_q)
      mctt_pkg::ST_IDLE: begin
        // fetch the addressed row, or slot 0 to open a tick
        if (in_valid_i) begin
          rd_en = 1'b1;
          if (in_data_i.func == mctt_pkg::FUNC_TICK) begin
            rd_addr = '0;
            ptr_d   = '0;
            cls_d   = 1'b1;
            state_d = mctt_pkg::ST_TICK;
          end else begin
            rd_addr = AW'(in_data_i.timer_index);
            state_d = mctt_pkg::ST_CMD;
          end
        end
      end

      mctt_pkg::ST_CMD: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_item.is_fire     = 1'b0;
          out_item.fired_timer = cmd_q.timer_index;
          out_item.last        = 1'b1;
          out_item.timer_status = mctt_pkg::STATUS_CREATED;
          out_item.accepted    = 1'b0;
          if (idx_ok) begin
            out_item.timer_status = cur_run;
            unique case (cmd_q.func)
              mctt_pkg::FUNC_SETUP: begin
                wr_en             = 1'b1;
                wr_entry.reload   = cmd_q.reload_ticks[COUNT_WIDTH-1:0];
                wr_entry.count    = cmd_q.reload_ticks[COUNT_WIDTH-1:0];
                wr_entry.periodic = cmd_q.periodic;
                wr_entry.hard     = cmd_q.hard_mode;
                run_wr_en         = 1'b1;
                run_wr_val        = mctt_pkg::STATUS_CREATED;
                out_item.timer_status = mctt_pkg::STATUS_CREATED;
                out_item.accepted = 1'b1;
              end
              mctt_pkg::FUNC_START: begin
                if (cur_run != mctt_pkg::STATUS_STARTED) begin
                  wr_en          = 1'b1;
                  wr_entry.count = ent.reload;
                  run_wr_en      = 1'b1;
                  run_wr_val     = mctt_pkg::STATUS_STARTED;
                  out_item.timer_status = mctt_pkg::STATUS_STARTED;
                  out_item.accepted = 1'b1;
                end
              end
              mctt_pkg::FUNC_STOP: begin
                if (cur_run == mctt_pkg::STATUS_STARTED) begin
                  run_wr_en  = 1'b1;
                  run_wr_val = mctt_pkg::STATUS_STOPPED;
                  out_item.timer_status = mctt_pkg::STATUS_STOPPED;
                  out_item.accepted = 1'b1;
                end
              end
              default: begin
                // ticks never land here
                out_item.accepted = 1'b0;
              end
            endcase
          end
          state_d = mctt_pkg::ST_IDLE;
        end
      end

      mctt_pkg::ST_TICK: begin
        // a new firing pushes the held one out, so it waits for room
        if (!fire || !pend_vld_q || out_free) begin
          if (part) begin
            wr_en          = 1'b1;
            wr_entry.count = new_count;
          end
          if (fire) begin
            run_wr_en  = !ent.periodic;
            run_wr_val = mctt_pkg::STATUS_STOPPED;
            if (pend_vld_q) begin
              out_load = 1'b1;
              out_item = pend_q;
            end
            pend_vld_d          = 1'b1;
            pend_d.is_fire      = 1'b1;
            pend_d.fired_timer  = IW'(ptr_q);
            pend_d.timer_status = fire_status;
            pend_d.accepted     = 1'b1;
            pend_d.last         = 1'b0;
          end
          if (ptr_q == LAST_SLOT) begin
            if (cls_q) begin
              // hard pass done, start the soft pass
              cls_d   = 1'b0;
              ptr_d   = '0;
              rd_en   = 1'b1;
              rd_addr = '0;
            end else begin
              state_d = mctt_pkg::ST_FLUSH;
            end
          end else begin
            ptr_d   = ptr_q + AW'(1);
            rd_en   = 1'b1;
            rd_addr = ptr_q + AW'(1);
          end
        end
      end

      mctt_pkg::ST_FLUSH: begin
        // release the final firing with last set; a quiet tick ends here
        if (!pend_vld_q) begin
          state_d = mctt_pkg::ST_IDLE;
        end else if (out_free) begin
          out_load      = 1'b1;
          out_item      = pend_q;
          out_item.last = 1'b1;
          pend_vld_d    = 1'b0;
          state_d       = mctt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = mctt_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mctt_pkg::ST_IDLE;
      ptr_q      <= '0;
      cls_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        vld_q[i] <= 1'b0;
        run_q[i] <= mctt_pkg::STATUS_STOPPED;
      end
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      cls_q      <= cls_d;
      pend_vld_q <= pend_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (run_wr_en) begin
        run_q[cur_addr] <= run_wr_val;
      end
    end
  end

  // payload and timer table
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q <= in_data_i;
    end
    pend_q <= pend_d;
    if (out_load) begin
      out_q <= out_item;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_vld_q <= vld_q[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/mctt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mctt_checker: port-level checks for the multi-channel tick timer
// watches the two channels and the fields of each result transaction
// ----------------------------------------------------------------------------
module mctt_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire mctt_pkg::out_item_t out_data_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one transaction at a time: the block is busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an accept");

  // an acknowledgement is always the only and final result of its command
  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_fire |-> out_data_o.last)
    else $error("acknowledgement without last");

  // a firing is always accepted and leaves the timer started or stopped
  a_fire_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_fire |->
      out_data_o.accepted &&
      (out_data_o.timer_status != mctt_pkg::STATUS_CREATED))
    else $error("bad expiry report fields");

endmodule

bind multi_channel_tick_timer mctt_checker u_mctt_checker (.*);
`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: multi-channel tick timer testbench
// drives setup, start, stop and tick transactions into the timer table,
// predicts every acknowledgement and expiry report from a local copy of the
// timer table, and checks each report field by field under random idling
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TIMERS    = 16;
  localparam int unsigned RW        = mctt_pkg::RELOAD_W;
  localparam int unsigned IW        = mctt_pkg::IDX_W;
  // a tick walks the table twice, one slot per cycle when results are not stalled, plus pipeline slack
  localparam int unsigned TICK_CYC  = 2 * TIMERS + 2;
  localparam int unsigned DRAIN_CYC = 2 * TICK_CYC;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  mctt_pkg::in_item_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  mctt_pkg::out_item_t out_data_o;

  // idling knobs, changed per phase of the random traffic
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // local copy of the timer table
  logic [RW-1:0]       reload_tbl   [TIMERS];
  logic [RW-1:0]       count_tbl    [TIMERS];
  logic                periodic_tbl [TIMERS];
  logic                hard_tbl     [TIMERS];
  mctt_pkg::status_e   state_tbl    [TIMERS];

  // reports still owed by the block, oldest first
  mctt_pkg::out_item_t pending_reports[$];
  int                  mismatch_cnt = 0;

  multi_channel_tick_timer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------------
  // timer table prediction
  // ------------------------------------------------------------------------

  // every timer stopped and zeroed, as after reset
  task automatic clear_timer_table();
    for (int i = 0; i < TIMERS; i++) begin
      reload_tbl[i]   = '0;
      count_tbl[i]    = '0;
      periodic_tbl[i] = 1'b0;
      hard_tbl[i]     = 1'b0;
      state_tbl[i]    = mctt_pkg::STATUS_STOPPED;
    end
  endtask

  // one tick: hard timers first, then soft, each in ascending index order
  task automatic advance_tick();
    mctt_pkg::out_item_t fired[$];
    mctt_pkg::out_item_t rep;
    logic                cls;
    logic                hit;
    for (int c = 0; c < 2; c++) begin
      cls = (c == 0);
      for (int i = 0; i < TIMERS; i++) begin
        if (state_tbl[i] != mctt_pkg::STATUS_STARTED || hard_tbl[i] != cls) continue;
        // a count already at zero fires without decrementing
        hit = 1'b0;
        if (count_tbl[i] == '0) begin
          hit = 1'b1;
        end else begin
          count_tbl[i] = count_tbl[i] - RW'(1);
          hit = (count_tbl[i] == '0);
        end
        if (hit) begin
          if (periodic_tbl[i]) begin
            count_tbl[i] = reload_tbl[i];
          end else begin
            state_tbl[i] = mctt_pkg::STATUS_STOPPED;
          end
          rep.is_fire      = 1'b1;
          rep.fired_timer  = i[IW-1:0];
          rep.timer_status = state_tbl[i];
          rep.accepted     = 1'b1;
          rep.last         = 1'b0;
          fired.push_back(rep);
        end
      end
    end
    // a quiet tick owes nothing
    if (fired.size() != 0) fired[fired.size()-1].last = 1'b1;
    foreach (fired[k]) pending_reports.push_back(fired[k]);
  endtask

  // update the table for one accepted transaction and queue its reports
  task automatic apply_timer_item(mctt_pkg::in_item_t it);
    mctt_pkg::out_item_t ack;
    int                  idx;
    logic                took;
    idx  = int'(it.timer_index);
    took = 1'b0;
    case (it.func)
      mctt_pkg::FUNC_TICK: begin
        advance_tick();
        return;
      end
      mctt_pkg::FUNC_SETUP: begin
        // setup always wins, even over a started timer
        reload_tbl[idx]   = it.reload_ticks;
        count_tbl[idx]    = it.reload_ticks;
        periodic_tbl[idx] = it.periodic;
        hard_tbl[idx]     = it.hard_mode;
        state_tbl[idx]    = mctt_pkg::STATUS_CREATED;
        took = 1'b1;
      end
      mctt_pkg::FUNC_START: begin
        if (state_tbl[idx] != mctt_pkg::STATUS_STARTED) begin
          count_tbl[idx] = reload_tbl[idx];
          state_tbl[idx] = mctt_pkg::STATUS_STARTED;
          took = 1'b1;
        end
      end
      default: begin
        if (state_tbl[idx] == mctt_pkg::STATUS_STARTED) begin
          state_tbl[idx] = mctt_pkg::STATUS_STOPPED;
          took = 1'b1;
        end
      end
    endcase
    ack.is_fire      = 1'b0;
    ack.fired_timer  = it.timer_index;
    ack.timer_status = state_tbl[idx];
    ack.accepted     = took;
    ack.last         = 1'b1;
    pending_reports.push_back(ack);
  endtask

  // ------------------------------------------------------------------------
  // transaction helpers
  // ------------------------------------------------------------------------

  function automatic mctt_pkg::in_item_t timer_cmd(mctt_pkg::func_e f, int idx,
                                                   logic [RW-1:0] reload,
                                                   logic per, logic hard);
    mctt_pkg::in_item_t it;
    it.func         = f;
    it.timer_index  = idx[IW-1:0];
    it.reload_ticks = reload;
    it.periodic     = per;
    it.hard_mode    = hard;
    return it;
  endfunction

  // a tick ignores its other fields, so fill them with noise
  function automatic mctt_pkg::in_item_t tick_item();
    return timer_cmd(mctt_pkg::FUNC_TICK, $urandom_range(TIMERS - 1), $urandom(),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  // mostly short reloads so timers keep firing, now and then a wide one
  function automatic logic [RW-1:0] pick_reload();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(5);
    if (sel < 90) return $urandom();
    if (sel < 95) return '1;
    return '0;
  endfunction

  // one transaction: optional idle gap, then hold valid until accepted
  task automatic send_item(mctt_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    apply_timer_item(it);
  endtask

  // ------------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------------

  task automatic check_report(mctt_pkg::out_item_t got);
    mctt_pkg::out_item_t want;
    if (pending_reports.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t: unexpected report fire=%0b timer=%0d status=%0d acc=%0b last=%0b",
                 $realtime, got.is_fire, got.fired_timer, got.timer_status,
                 got.accepted, got.last);
      return;
    end
    want = pending_reports.pop_front();
    if (got.is_fire !== want.is_fire || got.fired_timer !== want.fired_timer ||
        got.timer_status !== want.timer_status || got.accepted !== want.accepted ||
        got.last !== want.last) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display({"%0t: report mismatch exp fire=%0b timer=%0d status=%0d acc=%0b last=%0b",
                  " got fire=%0b timer=%0d status=%0d acc=%0b last=%0b"},
                 $realtime, want.is_fire, want.fired_timer, want.timer_status,
                 want.accepted, want.last, got.is_fire, got.fired_timer,
                 got.timer_status, got.accepted, got.last);
    end
  endtask

  // result side: take reports, stall at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_report(out_data_o);
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // no timer running after reset, so a tick must stay silent
  task automatic test_quiet_tick_at_reset();
    send_item(tick_item());
  endtask

  // acks for accepted and ignored commands, extremes of reload and index
  task automatic test_command_acks();
    send_item(timer_cmd(mctt_pkg::FUNC_STOP, 0, '0, 1'b0, 1'b0));   // stop from stopped
    send_item(timer_cmd(mctt_pkg::FUNC_START, 3, '0, 1'b0, 1'b0));  // never set up, count zero
    send_item(timer_cmd(mctt_pkg::FUNC_START, 3, '1, 1'b1, 1'b1));  // start while started
    send_item(tick_item());                                         // zero count fires at once
    send_item(timer_cmd(mctt_pkg::FUNC_SETUP, 15, '1, 1'b1, 1'b1));
    send_item(timer_cmd(mctt_pkg::FUNC_SETUP, 0, '0, 1'b1, 1'b0));  // periodic zero reload
    send_item(timer_cmd(mctt_pkg::FUNC_SETUP, 5, 32'd1, 1'b0, 1'b1));
    send_item(timer_cmd(mctt_pkg::FUNC_SETUP, 9, 32'd2, 1'b1, 1'b0));
    send_item(timer_cmd(mctt_pkg::FUNC_STOP, 5, '0, 1'b0, 1'b0));   // stop from created
  endtask

  // hard before soft, index order, periodic reload and one-shot stop
  task automatic test_tick_order_and_reload();
    send_item(timer_cmd(mctt_pkg::FUNC_START, 15, '0, 1'b0, 1'b0));
    send_item(timer_cmd(mctt_pkg::FUNC_START, 0, '0, 1'b0, 1'b0));
    send_item(timer_cmd(mctt_pkg::FUNC_START, 5, '0, 1'b0, 1'b0));
    send_item(timer_cmd(mctt_pkg::FUNC_START, 9, '0, 1'b0, 1'b0));
    send_item(tick_item());
    send_item(tick_item());
  endtask

  // setup on a started timer takes it off the tick, a repeated stop then ignored
  task automatic test_setup_while_started();
    send_item(timer_cmd(mctt_pkg::FUNC_SETUP, 15, 32'd3, 1'b0, 1'b0));
    send_item(timer_cmd(mctt_pkg::FUNC_STOP, 9, '0, 1'b0, 1'b0));
    send_item(timer_cmd(mctt_pkg::FUNC_STOP, 9, '0, 1'b0, 1'b0));
    send_item(tick_item());
    send_item(timer_cmd(mctt_pkg::FUNC_START, 15, '0, 1'b0, 1'b0));
    repeat (3) send_item(tick_item());                              // third tick expires 15
    send_item(timer_cmd(mctt_pkg::FUNC_STOP, 0, '0, 1'b0, 1'b0));
    send_item(tick_item());                                         // quiet again
  endtask

  // random traffic under one idling setting
  task automatic test_random_traffic(int send_pct, int stall_pct, int n_items);
    int sent;
    int sel;
    int idx;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 6) begin
        // arm the whole table with short reloads so one tick fires many timers
        for (int i = 0; i < TIMERS; i++) begin
          send_item(timer_cmd(mctt_pkg::FUNC_SETUP, i, $urandom_range(2),
                              1'($urandom_range(1)), 1'($urandom_range(1))));
          send_item(timer_cmd(mctt_pkg::FUNC_START, i, $urandom(),
                              1'($urandom_range(1)), 1'($urandom_range(1))));
        end
        sent += 2 * TIMERS;
      end else begin
        sel = $urandom_range(99);
        idx = $urandom_range(TIMERS - 1);
        if (sel < 30)
          send_item(timer_cmd(mctt_pkg::FUNC_SETUP, idx, pick_reload(),
                              1'($urandom_range(1)), 1'($urandom_range(1))));
        else if (sel < 50)
          send_item(timer_cmd(mctt_pkg::FUNC_START, idx, $urandom(),
                              1'($urandom_range(1)), 1'($urandom_range(1))));
        else if (sel < 60)
          send_item(timer_cmd(mctt_pkg::FUNC_STOP, idx, $urandom(),
                              1'($urandom_range(1)), 1'($urandom_range(1))));
        else
          send_item(tick_item());
        sent++;
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    clear_timer_table();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_quiet_tick_at_reset();
    test_command_acks();
    test_tick_order_and_reload();
    test_setup_while_started();

    // idling phases: none, sender only, receiver only, both
    test_random_traffic(0, 0, 55);
    test_random_traffic(61, 0, 55);
    test_random_traffic(0, 61, 55);
    test_random_traffic(24, 24, 55);

    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    // catch any stray report after the last expected one
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
